### src/qvt_pkg.sv
// Shared types and constants for the quorum vote tracker.
// Holds field widths, command codes, controller states and the controller-to-datapath command.
// Depends on nothing.
package qvt_pkg;

    localparam int SLOTS    = 8;
    localparam int CMD_W    = 2;
    localparam int SENDER_W = 3;
    localparam int VIEW_W   = 32;
    localparam int SLOT_W   = 3;
    localparam int COUNT_W  = 4;
    localparam int RC_W     = 4;

    localparam logic [RC_W-1:0] RC_RESET = 4'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_RECORD    = 2'd0,
        CMD_CLEAR_ONE = 2'd1,
        CMD_CLEAR_ALL = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic load;
        logic find;
        logic apply;
    } t_dp_cmd;

endpackage

### src/qvt_if.sv
// Channel interfaces of the quorum vote tracker: command items, results, configuration.
// Depends on qvt_pkg for field widths.
interface qvt_item_if;
    import qvt_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           command;
    logic [SENDER_W-1:0]        sender;
    logic signed [VIEW_W-1:0]   view_tag;
    logic [SLOT_W-1:0]          slot_select;
    modport source (output valid, command, sender, view_tag, slot_select, input ready);
    modport sink   (input valid, command, sender, view_tag, slot_select, output ready);
endinterface

interface qvt_result_if;
    import qvt_pkg::*;
    logic               valid;
    logic               ready;
    logic               duplicate;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] vote_count;
    logic               table_full;
    modport source (output valid, duplicate, slot_index, vote_count, table_full, input ready);
    modport sink   (input valid, duplicate, slot_index, vote_count, table_full, output ready);
endinterface

interface qvt_cfg_if;
    import qvt_pkg::*;
    logic            valid;
    logic            ready;
    logic [RC_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### src/qvt_ctrl.sv
// Controller of the quorum vote tracker: sequences transfer, find and apply steps.
// Depends on qvt_pkg for the state type and the datapath command struct.
module qvt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output qvt_pkg::t_dp_cmd  o_cmd
);
    import qvt_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_apply_go;

    // apply only when the result register is free or being emptied
    assign w_apply_go = (r_state == S_APPLY) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_FIND;
            S_FIND:  n_state = S_APPLY;
            S_APPLY: begin
                if (w_apply_go) begin
                    n_state = i_in_valid ? S_FIND : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == S_IDLE) || w_apply_go;
        o_cmd.load  = i_in_valid && o_in_ready;
        o_cmd.find  = (r_state == S_FIND);
        o_cmd.apply = w_apply_go;
        if (w_apply_go) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_idle_to_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && i_in_valid |=> (r_state == S_FIND))
        else $error("transfer in idle did not start a find step");

    a_apply_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_apply_go |=> r_out_valid)
        else $error("applied item left no result");

    a_find_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |-> !o_in_ready)
        else $error("input ready during find step");

endmodule

### src/qvt_datapath.sv
// Datapath of the quorum vote tracker: slot table, slot searches, result register.
// Depends on qvt_pkg for widths, command codes and the command struct from qvt_ctrl.
module qvt_datapath #(
    parameter int NSLOT = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  qvt_pkg::t_dp_cmd             i_cmd,
    input  logic [qvt_pkg::CMD_W-1:0]    i_command,
    input  logic [qvt_pkg::SENDER_W-1:0] i_sender,
    input  logic [qvt_pkg::VIEW_W-1:0]   i_view_tag,
    input  logic [qvt_pkg::SLOT_W-1:0]   i_slot_select,
    input  logic                         i_cfg_we,
    input  logic [qvt_pkg::RC_W-1:0]     i_cfg_data,
    output logic                         o_duplicate,
    output logic [qvt_pkg::SLOT_W-1:0]   o_slot_index,
    output logic [qvt_pkg::COUNT_W-1:0]  o_vote_count,
    output logic                         o_table_full
);
    import qvt_pkg::*;

    // item registers
    logic [CMD_W-1:0]    r_cmd;
    logic [SENDER_W-1:0] r_sender;
    logic [VIEW_W-1:0]   r_view_tag;
    logic [SLOT_W-1:0]   r_slot_select;
    logic [RC_W-1:0]     r_replica_count;

    // slot table
    logic [VIEW_W-1:0] r_slot_view [NSLOT];
    logic [NSLOT-1:0]  r_slot_valid, n_slot_valid;
    logic [NSLOT-1:0]  r_vote_mask  [NSLOT];
    logic [NSLOT-1:0]  n_vote_mask  [NSLOT];
    logic [NSLOT-1:0]  w_view_we;

    // find step results
    logic             r_dup;
    logic [NSLOT-1:0] r_hit_oh;

    // result register
    logic               r_res_dup, n_res_dup;
    logic [SLOT_W-1:0]  r_res_idx, n_res_idx;
    logic [COUNT_W-1:0] r_res_count, n_res_count;
    logic               r_res_full, n_res_full;

    logic [RC_W-1:0]  w_n;
    logic [NSLOT-1:0] w_used, w_bit, w_eq;
    logic [NSLOT-1:0] w_hit_oh, w_match_oh, w_free_oh;
    logic             w_sender_ok, w_found, w_hit_dup;
    logic [NSLOT-1:0] w_res_oh, w_res_mask, w_sel_mask;

    always_comb begin
        if (r_replica_count == '0) begin
            w_n = RC_W'(1);
        end else if (r_replica_count > RC_W'(NSLOT)) begin
            w_n = RC_W'(NSLOT);
        end else begin
            w_n = r_replica_count;
        end
        w_sender_ok = {1'b0, r_sender} < w_n;
        for (int i = 0; i < NSLOT; i++) begin
            w_used[i] = RC_W'(i) < w_n;
            w_bit[i]  = r_sender == SENDER_W'(i);
            w_eq[i]   = r_slot_valid[i] && (r_slot_view[i] == r_view_tag);
        end
    end

    // first-slot searches: scan down so the lowest hit wins
    always_comb begin
        w_hit_oh   = '0;
        w_match_oh = '0;
        w_free_oh  = '0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (w_used[i] && ((r_vote_mask[i] & w_bit) != '0)) begin
                w_hit_oh    = '0;
                w_hit_oh[i] = 1'b1;
            end
            if (w_used[i] && w_eq[i]) begin
                w_match_oh    = '0;
                w_match_oh[i] = 1'b1;
            end
            if (w_used[i] && !r_slot_valid[i]) begin
                w_free_oh    = '0;
                w_free_oh[i] = 1'b1;
            end
        end
        w_found   = |w_hit_oh;
        w_hit_dup = |(w_hit_oh & w_eq);
    end

    always_comb begin
        n_slot_valid = r_slot_valid;
        n_vote_mask  = r_vote_mask;
        w_view_we    = '0;
        n_res_dup    = 1'b0;
        n_res_full   = 1'b0;
        w_res_oh     = '0;
        w_res_mask   = '0;
        w_sel_mask   = '0;

        // withdraw the sender's vote for an older view
        if (i_cmd.find && (r_cmd == CMD_RECORD) && w_sender_ok && w_found && !w_hit_dup) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (w_hit_oh[i]) begin
                    n_vote_mask[i] = r_vote_mask[i] & ~w_bit;
                    if ((n_vote_mask[i] & w_used) == '0) n_slot_valid[i] = 1'b0;
                end
            end
        end

        if (i_cmd.apply) begin
            unique case (t_cmd'(r_cmd))
                CMD_CLEAR_ONE: begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (r_slot_select == SLOT_W'(i)) begin
                            n_vote_mask[i]  = '0;
                            n_slot_valid[i] = 1'b0;
                        end
                    end
                end
                CMD_CLEAR_ALL: begin
                    n_slot_valid = '0;
                    for (int i = 0; i < NSLOT; i++) n_vote_mask[i] = '0;
                end
                CMD_RECORD: begin
                    if (w_sender_ok) begin
                        if (r_dup) begin
                            n_res_dup = 1'b1;
                            w_res_oh  = r_hit_oh;
                            for (int i = 0; i < NSLOT; i++) begin
                                if (r_hit_oh[i]) w_res_mask = r_vote_mask[i];
                            end
                        end else if (|w_match_oh) begin
                            w_res_oh = w_match_oh;
                            for (int i = 0; i < NSLOT; i++) begin
                                if (w_match_oh[i]) w_sel_mask = r_vote_mask[i];
                            end
                            n_res_dup  = |(w_sel_mask & w_bit);
                            w_res_mask = w_sel_mask | w_bit;
                            for (int i = 0; i < NSLOT; i++) begin
                                if (w_match_oh[i]) n_vote_mask[i] = w_res_mask;
                            end
                        end else if (|w_free_oh) begin
                            w_res_oh   = w_free_oh;
                            w_view_we  = w_free_oh;
                            w_res_mask = w_bit;
                            for (int i = 0; i < NSLOT; i++) begin
                                if (w_free_oh[i]) begin
                                    n_slot_valid[i] = 1'b1;
                                    n_vote_mask[i]  = w_bit;
                                end
                            end
                        end else begin
                            n_res_full = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        n_res_idx   = '0;
        n_res_count = '0;
        for (int i = 0; i < NSLOT; i++) begin
            if (w_res_oh[i]) n_res_idx = n_res_idx | SLOT_W'(i);
            n_res_count = n_res_count + COUNT_W'(w_res_mask[i] & w_used[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid    <= '0;
            r_replica_count <= RC_RESET;
            for (int i = 0; i < NSLOT; i++) r_vote_mask[i] <= '0;
        end else begin
            r_slot_valid <= n_slot_valid;
            r_vote_mask  <= n_vote_mask;
            if (i_cfg_we) r_replica_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NSLOT; i++) begin
            if (w_view_we[i]) r_slot_view[i] <= r_view_tag;
        end
        if (i_cmd.load) begin
            r_cmd         <= i_command;
            r_sender      <= i_sender;
            r_view_tag    <= i_view_tag;
            r_slot_select <= i_slot_select;
        end
        if (i_cmd.find) begin
            r_dup    <= w_found && w_hit_dup;
            r_hit_oh <= w_hit_oh;
        end
        if (i_cmd.apply) begin
            r_res_dup   <= n_res_dup;
            r_res_idx   <= n_res_idx;
            r_res_count <= n_res_count;
            r_res_full  <= n_res_full;
        end
    end

    assign o_duplicate  = r_res_dup;
    assign o_slot_index = r_res_idx;
    assign o_vote_count = r_res_count;
    assign o_table_full = r_res_full;

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply && (r_cmd == CMD_CLEAR_ALL) |=> (r_slot_valid == '0))
        else $error("slots still valid after clear-all");

    a_find_keeps_joins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.find |-> (w_view_we == '0))
        else $error("view written during find step");

endmodule

### src/quorum_vote_tracker.sv
// Quorum vote tracker top level: channels, controller and slot datapath.
// Depends on qvt_pkg, the channel interfaces, qvt_ctrl and qvt_datapath.
//
// Each command goes through a find step that looks up the sender's
// earlier vote and withdraws it when it was for another view, then an apply
// step that joins the vote to the matching or first free slot, or clears
// slots, and loads the result register. The next command transfers during
// the apply step, so a new command is taken while the last one is applied.
// A result not yet taken holds the apply step. No clearing pass is needed
// after reset. Configuration is always ready; write it only while the
// block is idle.
module quorum_vote_tracker #(
    parameter int MAX_REPLICAS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    qvt_item_if.sink            i_item,
    qvt_result_if.source        o_result,
    qvt_cfg_if.sink             i_cfg
);
    import qvt_pkg::*;

    localparam int NSLOT = (MAX_REPLICAS < SLOTS) ? MAX_REPLICAS : SLOTS;

    t_dp_cmd w_cmd;

    assign i_cfg.ready = 1'b1;

    qvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (w_cmd)
    );

    qvt_datapath #(
        .NSLOT (NSLOT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_command     (i_item.command),
        .i_sender      (i_item.sender),
        .i_view_tag    (i_item.view_tag),
        .i_slot_select (i_item.slot_select),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .o_duplicate   (o_result.duplicate),
        .o_slot_index  (o_result.slot_index),
        .o_vote_count  (o_result.vote_count),
        .o_table_full  (o_result.table_full)
    );

endmodule

### test/vote_tally_checker.sv
// Checker for the quorum vote tracker: watches the item, result and config channels,
// predicts each result from its own copy of the slot table and compares in order.
// Depends on qvt_pkg and the channel interfaces in qvt_if.sv.
module vote_tally_checker #(
    parameter int MAX_REPLICAS = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    qvt_item_if      item_ch,
    qvt_result_if    res_ch,
    qvt_cfg_if       cfg_ch,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import qvt_pkg::*;

    typedef struct packed {
        logic               duplicate;
        logic [SLOT_W-1:0]  slot_index;
        logic [COUNT_W-1:0] vote_count;
        logic               table_full;
    } t_tally;

    logic [VIEW_W-1:0]  view_of [SLOTS];
    logic               live    [SLOTS];
    logic [SLOTS-1:0]   voters  [SLOTS];
    logic [RC_W-1:0]    replicas;

    t_tally tally_q [$];
    int     mismatches;
    int     checked;

    function automatic logic [COUNT_W-1:0] ones(input logic [SLOTS-1:0] v);
        int c;
        c = 0;
        for (int i = 0; i < SLOTS; i++) c += v[i];
        return c[COUNT_W-1:0];
    endfunction

    // Apply one command to the local slot table and work out its result.
    task automatic predict_tally(input logic [CMD_W-1:0] cmd, input logic [SENDER_W-1:0] from,
                                 input logic [VIEW_W-1:0] view, input logic [SLOT_W-1:0] sel,
                                 output t_tally r);
        int               n;
        int               lim;
        int               hit;
        int               join_at;
        int               free_at;
        logic [SLOTS:0]   span;
        logic [SLOTS-1:0] used;
        logic [SLOTS-1:0] me;
        r   = '0;
        lim = (MAX_REPLICAS > SLOTS) ? SLOTS : MAX_REPLICAS;
        n   = int'(replicas);
        if (n < 1) n = 1;
        if (n > lim) n = lim;
        span = ({{SLOTS{1'b0}}, 1'b1} << n) - 1'b1;
        used = span[SLOTS-1:0];
        me   = {{(SLOTS-1){1'b0}}, 1'b1} << from;
        case (cmd)
            CMD_CLEAR_ONE: begin
                voters[sel] = '0;
                live[sel]   = 1'b0;
            end
            CMD_CLEAR_ALL: begin
                for (int i = 0; i < SLOTS; i++) begin
                    voters[i] = '0;
                    live[i]   = 1'b0;
                end
            end
            CMD_RECORD: begin
                if (int'(from) < n) begin
                    hit = -1;
                    for (int i = 0; i < n; i++)
                        if (hit < 0 && (voters[i] & me) != '0) hit = i;
                    if (hit >= 0 && live[hit] && view_of[hit] == view) begin
                        r.duplicate  = 1'b1;
                        r.slot_index = hit[SLOT_W-1:0];
                        r.vote_count = ones(voters[hit] & used);
                    end else begin
                        // withdraw the vote for the older view, free the slot once empty
                        if (hit >= 0) begin
                            voters[hit] = voters[hit] & ~me;
                            if ((voters[hit] & used) == '0) live[hit] = 1'b0;
                        end
                        join_at = -1;
                        free_at = -1;
                        for (int i = 0; i < n; i++)
                            if (join_at < 0 && live[i] && view_of[i] == view) join_at = i;
                        for (int i = 0; i < n; i++)
                            if (free_at < 0 && !live[i]) free_at = i;
                        if (join_at >= 0) begin
                            r.duplicate     = |(voters[join_at] & me);
                            voters[join_at] = voters[join_at] | me;
                            r.slot_index    = join_at[SLOT_W-1:0];
                            r.vote_count    = ones(voters[join_at] & used);
                        end else if (free_at >= 0) begin
                            view_of[free_at] = view;
                            live[free_at]    = 1'b1;
                            voters[free_at]  = me;
                            r.slot_index     = free_at[SLOT_W-1:0];
                            r.vote_count     = COUNT_W'(1);
                        end else begin
                            r.table_full = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_tally want;
        t_tally got;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                live[i]   = 1'b0;
                voters[i] = '0;
            end
            replicas = RC_RESET;
            tally_q.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) replicas = cfg_ch.data;
            if (res_ch.valid && res_ch.ready) begin
                got.duplicate  = res_ch.duplicate;
                got.slot_index = res_ch.slot_index;
                got.vote_count = res_ch.vote_count;
                got.table_full = res_ch.table_full;
                if (tally_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result dup=%0d slot=%0d count=%0d full=%0d",
                                 $realtime, got.duplicate, got.slot_index, got.vote_count,
                                 got.table_full);
                end else begin
                    want = tally_q.pop_front();
                    checked++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch, expected dup=%0d slot=%0d count=%0d full=%0d",
                                     $realtime, want.duplicate, want.slot_index,
                                     want.vote_count, want.table_full);
                            $display("%0t: mismatch, actual   dup=%0d slot=%0d count=%0d full=%0d",
                                     $realtime, got.duplicate, got.slot_index,
                                     got.vote_count, got.table_full);
                        end
                    end
                end
            end
            if (item_ch.valid && item_ch.ready) begin
                predict_tally(item_ch.command, item_ch.sender, item_ch.view_tag,
                              item_ch.slot_select, want);
                tally_q = {tally_q, want};
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= tally_q.size();
        o_checked    <= checked;
    end

endmodule

### test/tb_top.sv
// Testbench top for the quorum vote tracker: clock, reset, stimulus, receiver stalls,
// watchdog and verdict. Depends on qvt_pkg, the channel interfaces, the block
// and vote_tally_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qvt_pkg::*;

    localparam int PERIOD      = 12;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam logic [CMD_W-1:0]  CMD_NONE = 2'd3;
    localparam logic [VIEW_W-1:0] VIEW_MIN = 32'h8000_0000;
    localparam logic [VIEW_W-1:0] VIEW_MAX = 32'h7FFF_FFFF;
    localparam logic [VIEW_W-1:0] VIEW_NEG = 32'hFFFF_FFFF;

    logic i_clk;
    logic i_rst_n;

    qvt_item_if   item_ch ();
    qvt_result_if res_ch ();
    qvt_cfg_if    cfg_ch ();

    int fail_count;
    int pending;
    int checked;
    int sent;
    int settings;
    int n_eff;
    bit idle_on;
    bit hold_req;

    quorum_vote_tracker #(
        .MAX_REPLICAS(8)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    vote_tally_checker #(
        .MAX_REPLICAS(8)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .item_ch      (item_ch),
        .res_ch       (res_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial i_clk = 1'b0;
    always #(PERIOD / 2) i_clk = ~i_clk;

    // One command transfer, with an optional idle burst in front.
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [SENDER_W-1:0] from,
                         input logic [VIEW_W-1:0] view, input logic [SLOT_W-1:0] sel);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.command     <= cmd;
        item_ch.sender      <= from;
        item_ch.view_tag    <= view;
        item_ch.slot_select <= sel;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    // Hold the sender until every expected result has come back.
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_replicas(input logic [RC_W-1:0] value);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        n_eff = (value == 0) ? 1 : ((value > 8) ? 8 : int'(value));
        settings++;
    endtask

    // Mostly votes from live replicas over a few shared views, plus clears and noise.
    task automatic run_phase(input int count);
        logic [VIEW_W-1:0]   pool [4];
        logic [CMD_W-1:0]    cmd;
        logic [SENDER_W-1:0] from;
        logic [VIEW_W-1:0]   view;
        int                  pick;
        int                  k;
        for (k = 0; k < 4; k++) pool[k] = $urandom;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 84)      cmd = CMD_RECORD;
            else if (pick < 92) cmd = CMD_CLEAR_ONE;
            else if (pick < 96) cmd = CMD_CLEAR_ALL;
            else                cmd = CMD_NONE;
            if ($urandom_range(0, 9) == 0) from = SENDER_W'($urandom);
            else                           from = SENDER_W'($urandom_range(0, n_eff - 1));
            if ($urandom_range(0, 7) == 0) view = $urandom;
            else                           view = pool[$urandom_range(0, 3)];
            offer(cmd, from, view, SLOT_W'($urandom));
        end
    endtask

    initial begin
        res_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        @(posedge i_rst_n);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.command     = CMD_RECORD;
        item_ch.sender      = '0;
        item_ch.view_tag    = '0;
        item_ch.slot_select = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = RC_RESET;
        idle_on             = 1'b1;
        hold_req            = 1'b0;
        sent                = 0;
        settings            = 1;
        n_eff               = int'(RC_RESET);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // three replicas after reset: join, duplicate, withdraw and move, ignored senders
        offer(CMD_RECORD, 3'd0, VIEW_MIN, 3'd0);
        offer(CMD_RECORD, 3'd0, VIEW_MIN, 3'd0);
        offer(CMD_RECORD, 3'd1, VIEW_MIN, 3'd0);
        offer(CMD_RECORD, 3'd2, VIEW_MAX, 3'd0);
        offer(CMD_RECORD, 3'd3, VIEW_MIN, 3'd0);
        offer(CMD_RECORD, 3'd7, VIEW_MAX, 3'd7);
        offer(CMD_RECORD, 3'd0, VIEW_MAX, 3'd0);
        offer(CMD_RECORD, 3'd1, VIEW_MAX, 3'd0);
        offer(CMD_RECORD, 3'd0, VIEW_NEG, 3'd0);
        offer(CMD_RECORD, 3'd1, 32'd0, 3'd0);
        offer(CMD_NONE, 3'd7, VIEW_NEG, 3'd7);
        offer(CMD_CLEAR_ONE, 3'd0, 32'd0, 3'd7);
        offer(CMD_CLEAR_ONE, 3'd0, 32'd0, 3'd0);
        offer(CMD_CLEAR_ALL, 3'd0, 32'd0, 3'd0);

        // fill slots with high senders, then shrink so those slots block the table
        write_replicas(4'd8);
        offer(CMD_RECORD, 3'd5, 32'h11, 3'd0);
        offer(CMD_RECORD, 3'd6, 32'h22, 3'd0);
        offer(CMD_RECORD, 3'd7, 32'h33, 3'd0);
        offer(CMD_RECORD, 3'd0, 32'h44, 3'd0);
        offer(CMD_RECORD, 3'd1, 32'h55, 3'd0);
        offer(CMD_RECORD, 3'd2, 32'h66, 3'd0);
        write_replicas(4'd3);
        offer(CMD_RECORD, 3'd0, 32'h77, 3'd0);
        offer(CMD_RECORD, 3'd1, 32'h11, 3'd0);
        offer(CMD_CLEAR_ONE, 3'd0, 32'd0, 3'd2);
        offer(CMD_RECORD, 3'd0, 32'h77, 3'd0);

        write_replicas(4'd0);
        idle_on = ($urandom_range(0, 3) != 0);
        run_phase(40);
        write_replicas(4'd15);
        idle_on = 1'b1;
        run_phase(60);
        hold_req = 1'b1;
        run_phase(60);
        write_replicas(4'd1);
        idle_on = ($urandom_range(0, 3) != 0);
        run_phase(30);
        write_replicas(4'd8);
        idle_on = 1'b1;
        run_phase(60);
        drain();
        run_phase(40);
        write_replicas(4'd2);
        idle_on = ($urandom_range(0, 3) != 0);
        run_phase(40);
        write_replicas(4'd5);
        idle_on = ($urandom_range(0, 3) != 0);
        run_phase(50);
        write_replicas(RC_W'($urandom_range(0, 15)));
        idle_on = 1'b1;
        run_phase(40);
        write_replicas(4'd4);
        idle_on = 1'b0;
        run_phase(40);

        drain();
        repeat (8) @(negedge i_clk);
        $display("Sent %0d commands under %0d replica-count settings; %0d tallies checked,",
                 sent, settings, checked);
        $display("including table-full, withdrawn votes, clears and a long result back-pressure.");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
src/qvt_pkg.sv
src/qvt_if.sv
src/qvt_ctrl.sv
src/qvt_datapath.sv
src/quorum_vote_tracker.sv
test/vote_tally_checker.sv
test/tb_top.sv
